[sv/pfa_pkg.sv]
// shared types and constants of the page frame allocator
// used by page_frame_allocator_core; no dependencies
package pfa_pkg;

  localparam int FRAMES     = 256;
  localparam int VPAGES     = 256;
  localparam int HALF_DEPTH = 2 * FRAMES;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int VPN_W      = $clog2(VPAGES);
  localparam int FC_W       = $clog2(FRAMES + 1);
  localparam int HC_W       = $clog2(HALF_DEPTH + 1);
  localparam int LIST_AW    = $clog2(HALF_DEPTH);
  localparam int SLOT_W     = FRAME_W + 1;
  localparam int PADDR_W    = 4;

  typedef enum logic [2:0] {
    FN_INIT   = 3'd0,
    FN_GRAB   = 3'd1,
    FN_FREE   = 3'd2,
    FN_TAKE   = 3'd3,
    FN_GIVE   = 3'd4,
    FN_LOOKUP = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_UNMAPPED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_FRAME_COUNT = 2'd0,
    REG_RSV_FIRST   = 2'd1,
    REG_RSV_LAST    = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INIT,
    S_GRAB2,
    S_FREE2,
    S_LOOK2,
    S_FILL,
    S_TAKE2,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [2:0]         kprot;
    logic [2:0]         uprot;
    logic [FRAME_W-1:0] frame;
  } pte_t;

endpackage

[sv/page_frame_allocator_core.sv]
// page frame allocator top level: free frame stack, page table and half-slot list
// depends on pfa_pkg
//
// One request is worked at a time; the next is taken once the result sits in the
// output register. Grab, free, lookup and take-half go through accept, a memory
// read, the read-modify-write (a plain read for lookup) and the result load. Init
// walks the frames one per cycle, min(frame_count, 256) of them. Give-half
// searches the slot list newest first at one entry per cycle, then closes the
// gap one entry per cycle; the single read port of the slot list sets that pace.
module page_frame_allocator_core import pfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           func_i,
  input  logic [VPN_W-1:0]     vpn_i,
  input  logic [2:0]           kernel_prot_i,
  input  logic [2:0]           user_prot_i,
  input  logic [FRAME_W-1:0]   frame_i,
  input  logic                 half_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [FRAME_W-1:0]   result_frame_o,
  output logic                 result_half_o,
  output logic                 entry_valid_o,
  output logic [2:0]           entry_kernel_prot_o,
  output logic [2:0]           entry_user_prot_o,
  output logic [FC_W-1:0]      free_count_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  state_e state_q, state_d;

  logic [8:0]           frame_count_q;
  logic [7:0]           rsv_first_q, rsv_last_q;

  logic [2:0]           func_q, func_d;
  logic [VPN_W-1:0]     vpn_q, vpn_d;
  logic [2:0]           kp_q, kp_d, up_q, up_d;
  logic [FRAME_W-1:0]   frm_q, frm_d;
  logic                 half_q, half_d;

  logic [FC_W-1:0]      fc_q, fc_d;
  logic [HC_W-1:0]      hc_q, hc_d;
  logic [HC_W-1:0]      idx_q, idx_d;

  logic [1:0]           res_status_q, res_status_d;
  logic [FRAME_W-1:0]   res_frame_q, res_frame_d;
  logic                 res_half_q, res_half_d;
  logic                 res_ev_q, res_ev_d;
  logic [2:0]           res_ek_q, res_ek_d, res_eu_q, res_eu_d;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q, out_status_d;
  logic [FRAME_W-1:0]   out_frame_q, out_frame_d;
  logic                 out_half_q, out_half_d;
  logic                 out_ev_q, out_ev_d;
  logic [2:0]           out_ek_q, out_ek_d, out_eu_q, out_eu_d;
  logic [FC_W-1:0]      out_fc_q, out_fc_d;

  // memories
  logic [FRAME_W-1:0]   stk_mem [FRAMES];
  pte_t                 pt_mem  [VPAGES];
  logic [SLOT_W-1:0]    lst_mem [HALF_DEPTH];
  logic [VPAGES-1:0]    pt_wr_q;

  logic [FRAME_W-1:0]   stk_rd_q;
  pte_t                 pt_rd_q;
  logic                 pt_hit_q;
  logic [SLOT_W-1:0]    lst_rd_q;

  logic                 stk_we;
  logic [FRAME_W-1:0]   stk_waddr, stk_wdata, stk_raddr;
  logic                 pt_we, pt_clr;
  pte_t                 pt_wdata;
  logic                 lst_we;
  logic [LIST_AW-1:0]   lst_waddr, lst_raddr;
  logic [SLOT_W-1:0]    lst_wdata;

  logic [FC_W-1:0]      fc_m1, n_frames;
  logic [HC_W-1:0]      hc_m1, idx_p1, idx_p2, idx_m1;
  logic [FRAME_W-1:0]   init_f;
  logic                 init_rsv, stk_room, lst_room, load_out, found;
  pte_t                 pt_ent;
  logic [SLOT_W-1:0]    buddy;

  assign fc_m1    = fc_q - FC_W'(1);
  assign hc_m1    = hc_q - HC_W'(1);
  assign idx_p1   = idx_q + HC_W'(1);
  assign idx_p2   = idx_q + HC_W'(2);
  assign idx_m1   = idx_q - HC_W'(1);
  assign n_frames = (frame_count_q > 9'(FRAMES)) ? FC_W'(FRAMES) : FC_W'(frame_count_q);
  assign init_f   = idx_m1[FRAME_W-1:0];
  assign init_rsv = (rsv_last_q >= rsv_first_q) && (init_f >= rsv_first_q)
                    && (init_f <= rsv_last_q);
  assign stk_room = fc_q < FC_W'(FRAMES);
  assign lst_room = hc_q < HC_W'(HALF_DEPTH);
  assign pt_ent   = pt_hit_q ? pt_rd_q : '0;
  assign buddy    = {frm_q, ~half_q};
  assign found    = lst_rd_q == buddy;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign stk_raddr = fc_m1[FRAME_W-1:0];

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_FRAME_COUNT: prdata = {23'd0, frame_count_q};
      REG_RSV_FIRST:   prdata = {24'd0, rsv_first_q};
      REG_RSV_LAST:    prdata = {24'd0, rsv_last_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= 9'd256;
      rsv_first_q   <= '0;
      rsv_last_q    <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_FRAME_COUNT: frame_count_q <= pwdata[8:0];
        REG_RSV_FIRST:   rsv_first_q   <= pwdata[7:0];
        REG_RSV_LAST:    rsv_last_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        case (func_q)
          FN_INIT:   state_d = S_INIT;
          FN_GRAB:   state_d = (fc_q == '0) ? S_DONE : S_GRAB2;
          FN_FREE:   state_d = S_FREE2;
          FN_LOOKUP: state_d = S_LOOK2;
          FN_TAKE: begin
            if (hc_q != '0)      state_d = S_TAKE2;
            else if (fc_q != '0) state_d = S_FILL;
            else                 state_d = S_DONE;
          end
          FN_GIVE:   state_d = (hc_q == '0) ? S_DONE : S_SCAN;
          default:   state_d = S_DONE;
        endcase
      end
      S_INIT:  if (idx_q == '0) state_d = S_DONE;
      S_SCAN: begin
        if (found) state_d = (idx_p1 == hc_q) ? S_DONE : S_SHIFT;
        else if (idx_q == '0) state_d = S_DONE;
      end
      S_SHIFT: if (idx_p2 >= hc_q) state_d = S_DONE;
      S_GRAB2, S_FREE2, S_LOOK2, S_FILL, S_TAKE2: state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    func_d = func_q; vpn_d = vpn_q; kp_d = kp_q; up_d = up_q;
    frm_d = frm_q; half_d = half_q;
    fc_d = fc_q; hc_d = hc_q; idx_d = idx_q;
    res_status_d = res_status_q; res_frame_d = res_frame_q; res_half_d = res_half_q;
    res_ev_d = res_ev_q; res_ek_d = res_ek_q; res_eu_d = res_eu_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q; out_frame_d = out_frame_q; out_half_d = out_half_q;
    out_ev_d = out_ev_q; out_ek_d = out_ek_q; out_eu_d = out_eu_q; out_fc_d = out_fc_q;
    stk_we = 1'b0; stk_waddr = fc_q[FRAME_W-1:0]; stk_wdata = frm_q;
    pt_we = 1'b0; pt_clr = 1'b0; pt_wdata = pt_ent;
    lst_we = 1'b0; lst_waddr = '0; lst_wdata = {frm_q, half_q};
    lst_raddr = hc_m1[LIST_AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i; vpn_d = vpn_i; kp_d = kernel_prot_i; up_d = user_prot_i;
          frm_d = frame_i; half_d = half_i;
          res_status_d = ST_OK; res_frame_d = '0; res_half_d = 1'b0;
          res_ev_d = 1'b0; res_ek_d = '0; res_eu_d = '0;
        end
      end
      S_EXEC: begin
        case (func_q)
          FN_INIT: begin
            fc_d = '0; hc_d = '0; pt_clr = 1'b1;
            idx_d = HC_W'(n_frames);
          end
          FN_GRAB: if (fc_q == '0) res_status_d = ST_NO_FRAME;
          FN_TAKE: if (hc_q == '0 && fc_q == '0) res_status_d = ST_NO_FRAME;
          FN_GIVE: begin
            if (hc_q == '0) begin
              lst_we = 1'b1; lst_waddr = '0; hc_d = HC_W'(1);
            end else begin
              idx_d = hc_m1;
            end
          end
          default: ;
        endcase
      end
      S_INIT: begin
        if (idx_q != '0) begin
          if (!init_rsv && stk_room) begin
            stk_we = 1'b1; stk_wdata = init_f; fc_d = fc_q + FC_W'(1);
          end
          idx_d = idx_m1;
        end
      end
      S_GRAB2: begin
        fc_d = fc_m1;
        pt_we = 1'b1;
        pt_wdata = '{valid: 1'b1, kprot: kp_q, uprot: up_q, frame: stk_rd_q};
        res_frame_d = stk_rd_q;
      end
      S_FREE2: begin
        if (!pt_ent.valid) begin
          res_status_d = ST_UNMAPPED;
        end else begin
          pt_we = 1'b1;
          pt_wdata = pt_ent;
          pt_wdata.valid = 1'b0;
          if (stk_room) begin
            stk_we = 1'b1; stk_wdata = pt_ent.frame; fc_d = fc_q + FC_W'(1);
          end
        end
      end
      S_LOOK2: begin
        res_frame_d = pt_ent.frame; res_ev_d = pt_ent.valid;
        res_ek_d = pt_ent.kprot; res_eu_d = pt_ent.uprot;
      end
      S_FILL: begin
        // slot one of the fresh frame is handed out at once, slot zero stays
        fc_d = fc_m1;
        lst_we = 1'b1; lst_waddr = '0; lst_wdata = {stk_rd_q, 1'b0};
        hc_d = HC_W'(1);
        res_frame_d = stk_rd_q; res_half_d = 1'b1;
      end
      S_TAKE2: begin
        hc_d = hc_m1;
        res_frame_d = lst_rd_q[SLOT_W-1:1]; res_half_d = lst_rd_q[0];
      end
      S_SCAN: begin
        if (found) begin
          if (idx_p1 == hc_q) begin
            hc_d = hc_m1;
            if (stk_room) begin
              stk_we = 1'b1; fc_d = fc_q + FC_W'(1);
            end
          end else begin
            lst_raddr = idx_p1[LIST_AW-1:0];
          end
        end else if (idx_q == '0) begin
          if (lst_room) begin
            lst_we = 1'b1; lst_waddr = hc_q[LIST_AW-1:0]; hc_d = hc_q + HC_W'(1);
          end
        end else begin
          lst_raddr = idx_m1[LIST_AW-1:0];
          idx_d = idx_m1;
        end
      end
      S_SHIFT: begin
        lst_we = 1'b1; lst_waddr = idx_q[LIST_AW-1:0]; lst_wdata = lst_rd_q;
        if (idx_p2 < hc_q) begin
          lst_raddr = idx_p2[LIST_AW-1:0];
          idx_d = idx_p1;
        end else begin
          hc_d = hc_m1;
          if (stk_room) begin
            stk_we = 1'b1; fc_d = fc_q + FC_W'(1);
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_status_d = res_status_q; out_frame_d = res_frame_q; out_half_d = res_half_q;
          out_ev_d = res_ev_q; out_ek_d = res_ek_q; out_eu_d = res_eu_q; out_fc_d = fc_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
    if (pt_we) pt_mem[vpn_q] <= pt_wdata;
    pt_rd_q <= pt_mem[vpn_q];
    if (lst_we) lst_mem[lst_waddr] <= lst_wdata;
    lst_rd_q <= lst_mem[lst_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_wr_q  <= '0;
      pt_hit_q <= 1'b0;
    end else begin
      if (pt_clr) pt_wr_q <= '0;
      else if (pt_we) pt_wr_q[vpn_q] <= 1'b1;
      pt_hit_q <= pt_wr_q[vpn_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fc_q        <= '0;
      hc_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      hc_q        <= hc_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; vpn_q <= vpn_d; kp_q <= kp_d; up_q <= up_d;
    frm_q <= frm_d; half_q <= half_d;
    res_status_q <= res_status_d; res_frame_q <= res_frame_d; res_half_q <= res_half_d;
    res_ev_q <= res_ev_d; res_ek_q <= res_ek_d; res_eu_q <= res_eu_d;
    out_status_q <= out_status_d; out_frame_q <= out_frame_d; out_half_q <= out_half_d;
    out_ev_q <= out_ev_d; out_ek_q <= out_ek_d; out_eu_q <= out_eu_d; out_fc_q <= out_fc_d;
  end

  assign in_stall_o          = state_q != S_IDLE;
  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign result_frame_o      = out_frame_q;
  assign result_half_o       = out_half_q;
  assign entry_valid_o       = out_ev_q;
  assign entry_kernel_prot_o = out_ek_q;
  assign entry_user_prot_o   = out_eu_q;
  assign free_count_o        = out_fc_q;

  // checks
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FC_W'(FRAMES)) else $error("free stack count beyond depth");

  a_hc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= HC_W'(HALF_DEPTH)) else $error("slot list count beyond depth");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result without finished request");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC)) else $error("accepted request not started");

endmodule

[tb/sv/tb.sv]
// testbench for page_frame_allocator_core: directed table then random requests
// checked against an in-bench model of the frame stack, page table and slot list
// depends on pfa_pkg and page_frame_allocator_core
`timescale 1ns / 1ps
module tb;
  import pfa_pkg::*;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] vpn;
    logic [2:0] kp;
    logic [2:0] up;
    logic [7:0] fr;
    logic       hf;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rframe;
    logic       rhalf;
    logic       ev;
    logic [2:0] ek;
    logic [2:0] eu;
    logic [8:0] fcount;
  } rsp_t;

  typedef struct {
    req_t req;
    logic known;
    rsp_t rsp;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] func;
  logic [7:0] vpn, frame;
  logic [2:0] kprot, uprot;
  logic half;
  logic [1:0] status;
  logic [7:0] result_frame;
  logic result_half, entry_valid;
  logic [2:0] entry_kprot, entry_uprot;
  logic [8:0] free_count;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  page_frame_allocator_core u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .vpn_i(vpn), .kernel_prot_i(kprot), .user_prot_i(uprot),
    .frame_i(frame), .half_i(half), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .result_frame_o(result_frame), .result_half_o(result_half),
    .entry_valid_o(entry_valid), .entry_kernel_prot_o(entry_kprot),
    .entry_user_prot_o(entry_uprot), .free_count_o(free_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // model state
  int unsigned cfg_frames, cfg_rfirst, cfg_rlast;
  logic [7:0] stack_q[256];
  int unsigned stack_n;
  pte_t ptab[256];
  logic [8:0] slots[512];
  int unsigned slot_n;

  rsp_t expected_q[$];
  int errors, mism, n_results, n_sent;
  int send_idle, recv_idle;
  bit hold_recv;

  initial clk = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

  function automatic void push_frame(logic [7:0] f);
    if (stack_n < 256) begin
      stack_q[stack_n] = f;
      stack_n++;
    end
  endfunction

  function automatic void push_slot(logic [8:0] s);
    if (slot_n < 512) begin
      slots[slot_n] = s;
      slot_n++;
    end
  endfunction

  function automatic void reset_alloc();
    cfg_frames = 256; cfg_rfirst = 0; cfg_rlast = 0;
    stack_n = 0; slot_n = 0;
    foreach (ptab[i]) ptab[i] = '0;
  endfunction

  function automatic rsp_t predict_alloc(req_t r);
    rsp_t o;
    int unsigned n, f, i;
    logic [8:0] buddy;
    bit found;
    o = '0;
    case (r.func)
      FN_INIT: begin
        n = cfg_frames > 256 ? 256 : cfg_frames;
        stack_n = 0;
        for (i = n; i > 0; i--) begin
          f = i - 1;
          if (!(cfg_rlast >= cfg_rfirst && f >= cfg_rfirst && f <= cfg_rlast))
            push_frame(f[7:0]);
        end
        foreach (ptab[j]) ptab[j] = '0;
        slot_n = 0;
      end
      FN_GRAB: begin
        if (stack_n == 0) o.status = ST_NO_FRAME;
        else begin
          stack_n--;
          ptab[r.vpn] = '{valid: 1'b1, kprot: r.kp, uprot: r.up, frame: stack_q[stack_n]};
          o.rframe = stack_q[stack_n];
        end
      end
      FN_FREE: begin
        if (!ptab[r.vpn].valid) o.status = ST_UNMAPPED;
        else begin
          ptab[r.vpn].valid = 1'b0;
          push_frame(ptab[r.vpn].frame);
        end
      end
      FN_TAKE: begin
        if (slot_n == 0) begin
          if (stack_n == 0) o.status = ST_NO_FRAME;
          else begin
            stack_n--;
            push_slot({stack_q[stack_n], 1'b0});
            push_slot({stack_q[stack_n], 1'b1});
          end
        end
        if (o.status == ST_OK) begin
          slot_n--;
          o.rframe = slots[slot_n][8:1];
          o.rhalf = slots[slot_n][0];
        end
      end
      FN_GIVE: begin
        buddy = {r.fr, ~r.hf};
        found = 0;
        i = slot_n;
        while (i > 0 && !found) begin
          i--;
          if (slots[i] == buddy) found = 1;
        end
        if (found) begin
          for (int k = i; k + 1 < slot_n; k++) slots[k] = slots[k+1];
          slot_n--;
          push_frame(r.fr);
        end else push_slot({r.fr, r.hf});
      end
      FN_LOOKUP: begin
        o.rframe = ptab[r.vpn].frame;
        o.ev = ptab[r.vpn].valid;
        o.ek = ptab[r.vpn].kprot;
        o.eu = ptab[r.vpn].uprot;
      end
      default: ;
    endcase
    o.fcount = stack_n[8:0];
    return o;
  endfunction

  task automatic write_reg(reg_e idx, int unsigned val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = PADDR_W'(4 * idx); pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_FRAME_COUNT: cfg_frames = val & 9'h1FF;
      REG_RSV_FIRST:   cfg_rfirst = val & 8'hFF;
      default:         cfg_rlast = val & 8'hFF;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  // drive one request; known row checked against prediction, which is queued
  task automatic send_req(req_t r, logic known, rsp_t kr);
    rsp_t p;
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid = 1;
    {func, vpn, kprot, uprot, frame, half} = {r.func, r.vpn, r.kp, r.up, r.fr, r.hf};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_alloc(r);
    if (known && p != kr) begin
      errors++;
      $display("table row disagrees with prediction: %h vs %h", kr, p);
    end
    expected_q.push_back(p);
    n_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic req_t rand_req(int mode);
    req_t r;
    int unsigned k;
    r.vpn = 8'($urandom_range(mode == 0 ? 255 : 15));
    r.kp = 3'($urandom); r.up = 3'($urandom); r.fr = 8'($urandom); r.hf = 1'($urandom);
    k = $urandom_range(99);
    if (k < 1) r.func = FN_INIT;
    else if (k < 25) r.func = FN_GRAB;
    else if (k < 45) r.func = FN_FREE;
    else if (k < 60) r.func = FN_TAKE;
    else if (k < 80) r.func = FN_GIVE;
    else if (k < 97) r.func = FN_LOOKUP;
    else r.func = 3'(6 + $urandom_range(1));
    // give back a slot that was handed out, mostly
    if (r.func == FN_GIVE && slot_n > 0 && $urandom_range(2) != 0) begin
      k = $urandom_range(slot_n - 1);
      r.fr = slots[k][8:1];
      r.hf = ~slots[k][0];
    end
    return r;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    rsp_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = {status, result_frame, result_half, entry_valid, entry_kprot, entry_uprot,
             free_count};
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected request result %h", got);
        mism++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got != exp_r) begin
          errors++;
          if (mism < 10)
            $display({"mismatch: exp st=%0d fr=%0d h=%0d v=%0d k=%0d u=%0d n=%0d",
                      " | got st=%0d fr=%0d h=%0d v=%0d k=%0d u=%0d n=%0d"},
                     exp_r.status, exp_r.rframe, exp_r.rhalf, exp_r.ev, exp_r.ek, exp_r.eu,
                     exp_r.fcount, got.status, got.rframe, got.rhalf, got.ev, got.ek,
                     got.eu, got.fcount);
          mism++;
        end
      end
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(logic [2:0] f, logic [7:0] v, logic [2:0] k, logic [2:0] u,
                              logic [7:0] fr, logic hf, logic known, rsp_t r);
    row_t x;
    x.req = '{func: f, vpn: v, kp: k, up: u, fr: fr, hf: hf};
    x.known = known;
    x.rsp = r;
    return x;
  endfunction

  initial begin
    int phase;
    reset_alloc();
    errors = 0; mism = 0; n_results = 0; n_sent = 0;
    rst_n = 0; in_valid = 0; hold_recv = 0;
    func = 0; vpn = 0; kprot = 0; uprot = 0; frame = 0; half = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle = 0; recv_idle = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // after reset: empty stack and table
    dir_rows.push_back(mk(FN_GRAB, 8'd0, 3'd7, 3'd7, 8'd0, 1'b0, 1, '{ST_NO_FRAME, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(FN_FREE, 8'd255, 0, 0, 0, 0, 1, '{ST_UNMAPPED, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(FN_TAKE, 8'd0, 0, 0, 0, 0, 1, '{ST_NO_FRAME, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(FN_LOOKUP, 8'd255, 0, 0, 0, 0, 1, '{ST_OK, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(3'd6, 8'd255, 7, 7, 255, 1, 1, '{ST_OK, 0,0,0,0,0,0}));
    dir_rows.push_back(mk(3'd7, 8'd0, 0, 0, 0, 0, 1, '{ST_OK, 0,0,0,0,0,0}));
    // reset reserves frame 0 only: 255 frames, lowest first
    dir_rows.push_back(mk(FN_INIT, 0, 0, 0, 0, 0, 1, '{ST_OK, 0,0,0,0,0,9'd255}));
    dir_rows.push_back(mk(FN_GRAB, 8'd255, 3'd7, 3'd0, 0, 0, 1, '{ST_OK, 8'd1,0,0,0,0,9'd254}));
    dir_rows.push_back(mk(FN_GRAB, 8'd255, 3'd0, 3'd7, 0, 0, 1, '{ST_OK, 8'd2,0,0,0,0,9'd253}));
    dir_rows.push_back(mk(FN_LOOKUP, 8'd255, 0, 0, 0, 0, 1, '{ST_OK, 8'd2,0,1,0,7,9'd253}));
    dir_rows.push_back(mk(FN_FREE, 8'd255, 0, 0, 0, 0, 1, '{ST_OK, 0,0,0,0,0,9'd254}));
    dir_rows.push_back(mk(FN_LOOKUP, 8'd255, 0, 0, 0, 0, 1, '{ST_OK, 8'd2,0,0,0,7,9'd254}));
    dir_rows.push_back(mk(FN_FREE, 8'd255, 0, 0, 0, 0, 1, '{ST_UNMAPPED, 0,0,0,0,0,9'd254}));
    dir_rows.push_back(mk(FN_TAKE, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(FN_TAKE, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(FN_GIVE, 0, 0, 0, 8'd2, 1'b1, 0, '0));
    dir_rows.push_back(mk(FN_GIVE, 0, 0, 0, 8'd2, 1'b0, 0, '0));
    dir_rows.push_back(mk(FN_GIVE, 0, 0, 0, 8'd255, 1'b1, 0, '0));
    dir_rows.push_back(mk(FN_TAKE, 0, 0, 0, 0, 0, 0, '0));
    dir_rows.push_back(mk(FN_GRAB, 8'd0, 3'd5, 3'd2, 0, 0, 0, '0));
    dir_rows.push_back(mk(FN_LOOKUP, 8'd0, 0, 0, 0, 0, 0, '0));
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);
    wait_drained();

    // register extremes, then small pools so the stack runs dry often
    for (phase = 0; phase < 6; phase++) begin
      req_t r;
      int cnt;
      case (phase)
        0: begin write_reg(REG_FRAME_COUNT, 256); write_reg(REG_RSV_FIRST, 255);
                 write_reg(REG_RSV_LAST, 0); end
        1: begin write_reg(REG_FRAME_COUNT, 1); write_reg(REG_RSV_FIRST, 0);
                 write_reg(REG_RSV_LAST, 255); end
        2: begin write_reg(REG_FRAME_COUNT, 511); write_reg(REG_RSV_FIRST, 0);
                 write_reg(REG_RSV_LAST, 255); end
        default: begin
          write_reg(REG_FRAME_COUNT, $urandom_range(1, 40));
          write_reg(REG_RSV_FIRST, $urandom_range(0, 255));
          write_reg(REG_RSV_LAST, $urandom_range(0, 255));
        end
      endcase
      if (phase < 3) begin
        r = '0;
        send_req(r, 0, '0);
        r.func = FN_GRAB;
        send_req(r, 0, '0);
        r.func = FN_TAKE;
        send_req(r, 0, '0);
        wait_drained();
      end else begin
        case (phase)
          3: begin send_idle = 11; recv_idle = 83; end
          4: begin send_idle = 83; recv_idle = 11; end
          default: begin send_idle = 0; recv_idle = 0; end
        endcase
        r = '0;
        send_req(r, 0, '0);
        if (phase == 5) begin
          // long receiver hold while requests keep coming
          fork
            begin
              hold_recv = 1;
              for (int c = 0; c < 300; c++) @(posedge clk);
              hold_recv = 0;
            end
            for (cnt = 0; cnt < 40; cnt++) send_req(rand_req(1), 0, '0);
          join
        end
        for (cnt = 0; cnt < 520; cnt++) send_req(rand_req(cnt % 3 == 0 ? 0 : 1), 0, '0);
        wait_drained();
      end
    end

    $display("covered %0d requests, %0d results, register extremes and three idling mixes",
             n_sent, n_results);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", errors + expected_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[page_frame_allocator_core.f]
sv/pfa_pkg.sv
sv/page_frame_allocator_core.sv
tb/sv/tb.sv
